// ===== rtl/core/i2crpt_pkg.sv =====
`timescale 1ns / 1ps
// Package for the I2C register-pointer target: sizes, operation codes and
// the structs passed between the control stage and the top level. No deps.
package i2crpt_pkg;

  // Sizes of the pending write buffer and of one image bank
  localparam int PENDING_DEPTH = 32;
  localparam int IMAGE_DEPTH   = 256;

  localparam int PEND_AW    = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int CNT_W      = $clog2(PENDING_DEPTH + 1);
  localparam int IMG_AW     = $clog2(IMAGE_DEPTH);
  localparam int IMG_RAM_AW = IMG_AW + 1;  // bank bit on top of the entry index

  localparam logic [6:0] OWN_ADDR_RESET = 7'd23;

  typedef enum logic [2:0] {
    OP_ADDR_MATCH  = 3'd0,
    OP_RX_BYTE     = 3'd1,
    OP_TX_REQ      = 3'd2,
    OP_STOP        = 3'd3,
    OP_BUS_ERROR   = 3'd4,
    OP_IMAGE_WRITE = 3'd5,
    OP_PEND_READ   = 3'd6,
    OP_PEND_CLEAR  = 3'd7
  } op_e;

  // One request as held in the input register
  typedef struct packed {
    op_e        op;
    logic [6:0] matched_address;
    logic       direction_read;
    logic [7:0] bus_byte;
    logic       active_bank;
    logic       local_bank;
    logic [7:0] local_index;
    logic [7:0] local_value;
  } item_t;

  // Memory accesses issued by the control stage
  typedef struct packed {
    logic                  img_we;
    logic [IMG_RAM_AW-1:0] img_waddr;
    logic [7:0]            img_wdata;
    logic                  img_re;
    logic [IMG_RAM_AW-1:0] img_raddr;
    logic                  pnd_we;
    logic [PEND_AW-1:0]    pnd_waddr;
    logic [7:0]            pnd_wdata;
    logic                  pnd_re;
    logic [PEND_AW-1:0]    pnd_raddr;
  } mem_req_t;

  // Scalar part of one result, state after the step
  typedef struct packed {
    logic             tx_valid;
    logic             tx_hit;
    logic             pnd_hit;
    logic             pending_flag;
    logic [7:0]       pending_register;
    logic [CNT_W-1:0] pending_count;
    logic             transaction_active;
  } step_res_t;

endpackage

// ===== rtl/core/i2crpt_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module i2crpt_ram #(
  parameter int AW = 5,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata_r
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/i2crpt_ctrl.sv =====
`timescale 1ns / 1ps
// Transaction state of the I2C target: pointer, enables, pending buffer
// bookkeeping and own address. Uses i2crpt_pkg.
module i2crpt_ctrl import i2crpt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [6:0] cfg_own_address,
  input  logic       step,
  input  item_t      item,
  output mem_req_t   mem_req,
  output step_res_t  res
);

  logic [6:0]       own_addr_r;
  logic [7:0]       ptr_r, ptr_nxt;
  logic             exp_ptr_r, exp_ptr_nxt;
  logic             ignore_r, ignore_nxt;
  logic             bank_r, bank_nxt;
  logic             rx_en_r, rx_en_nxt;
  logic             tx_en_r, tx_en_nxt;
  logic             trans_r, trans_nxt;
  logic             pvalid_r, pvalid_nxt;
  logic [7:0]       pptr_r, pptr_nxt;
  logic [CNT_W-1:0] plen_r, plen_nxt;
  logic             tx_valid, tx_hit, pnd_hit;

  // own address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r <= OWN_ADDR_RESET;
    end else if (cfg_we) begin
      own_addr_r <= cfg_own_address;
    end
  end

  // next state and memory requests for one item
  always_comb begin
    ptr_nxt    = ptr_r;
    exp_ptr_nxt = exp_ptr_r;
    ignore_nxt = ignore_r;
    bank_nxt   = bank_r;
    rx_en_nxt  = rx_en_r;
    tx_en_nxt  = tx_en_r;
    trans_nxt  = trans_r;
    pvalid_nxt = pvalid_r;
    pptr_nxt   = pptr_r;
    plen_nxt   = plen_r;
    tx_valid   = 1'b0;
    tx_hit     = 1'b0;
    pnd_hit    = 1'b0;
    mem_req    = '0;
    mem_req.img_waddr = {item.local_bank, item.local_index[IMG_AW-1:0]};
    mem_req.img_wdata = item.local_value;
    mem_req.img_raddr = {bank_r, ptr_r[IMG_AW-1:0]};
    mem_req.pnd_waddr = plen_r[PEND_AW-1:0];
    mem_req.pnd_wdata = item.bus_byte;
    mem_req.pnd_raddr = item.local_index[PEND_AW-1:0];

    unique case (item.op)
      OP_ADDR_MATCH: begin
        if (item.matched_address == own_addr_r) begin
          trans_nxt = 1'b1;
          if (item.direction_read) begin
            bank_nxt  = item.active_bank;
            tx_en_nxt = 1'b1;
            rx_en_nxt = 1'b0;
          end else begin
            exp_ptr_nxt = 1'b1;
            ignore_nxt  = pvalid_r;
            if (!pvalid_r) begin
              plen_nxt = '0;
            end
            rx_en_nxt = 1'b1;
            tx_en_nxt = 1'b0;
          end
        end
      end
      OP_RX_BYTE: begin
        if (rx_en_r && !ignore_r) begin
          if (exp_ptr_r) begin
            ptr_nxt     = item.bus_byte;
            pptr_nxt    = item.bus_byte;
            plen_nxt    = '0;
            exp_ptr_nxt = 1'b0;
          end else if (plen_r < CNT_W'(PENDING_DEPTH)) begin
            mem_req.pnd_we = step;
            plen_nxt       = CNT_W'(plen_r + 1'b1);
          end
        end
      end
      OP_TX_REQ: begin
        if (tx_en_r) begin
          tx_valid       = 1'b1;
          tx_hit         = ({1'b0, ptr_r} < 9'(IMAGE_DEPTH));
          mem_req.img_re = step;
          ptr_nxt        = ptr_r + 8'd1;
        end
      end
      OP_STOP: begin
        rx_en_nxt = 1'b0;
        tx_en_nxt = 1'b0;
        if (ignore_r) begin
          ignore_nxt = 1'b0;
        end else if (plen_r != '0) begin
          pvalid_nxt = 1'b1;
        end
        exp_ptr_nxt = 1'b1;
        trans_nxt   = 1'b0;
      end
      OP_BUS_ERROR: begin
        rx_en_nxt = 1'b0;
        tx_en_nxt = 1'b0;
      end
      OP_IMAGE_WRITE: begin
        mem_req.img_we = step && ({1'b0, item.local_index} < 9'(IMAGE_DEPTH));
      end
      OP_PEND_READ: begin
        pnd_hit        = (9'(item.local_index) < 9'(plen_r));
        mem_req.pnd_re = step;
      end
      OP_PEND_CLEAR: begin
        if (pvalid_r) begin
          pvalid_nxt = 1'b0;
          plen_nxt   = '0;
        end
      end
    endcase
  end

  // result fields: state after the step
  always_comb begin
    res.tx_valid           = tx_valid;
    res.tx_hit             = tx_hit;
    res.pnd_hit            = pnd_hit;
    res.pending_flag       = pvalid_nxt;
    res.pending_register   = pptr_nxt;
    res.pending_count      = plen_nxt;
    res.transaction_active = trans_nxt;
  end

  // state registers advance once per processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r     <= '0;
      exp_ptr_r <= 1'b1;
      ignore_r  <= 1'b0;
      bank_r    <= 1'b0;
      rx_en_r   <= 1'b0;
      tx_en_r   <= 1'b0;
      trans_r   <= 1'b0;
      pvalid_r  <= 1'b0;
      pptr_r    <= '0;
      plen_r    <= '0;
    end else if (step) begin
      ptr_r     <= ptr_nxt;
      exp_ptr_r <= exp_ptr_nxt;
      ignore_r  <= ignore_nxt;
      bank_r    <= bank_nxt;
      rx_en_r   <= rx_en_nxt;
      tx_en_r   <= tx_en_nxt;
      trans_r   <= trans_nxt;
      pvalid_r  <= pvalid_nxt;
      pptr_r    <= pptr_nxt;
      plen_r    <= plen_nxt;
    end
  end

`ifndef SYNTH
  // transmit only inside a transaction
  a_tx_in_trans: assert property (@(posedge clk) disable iff (!rst_n)
    tx_en_r |-> trans_r) else $error("transmit enabled outside transaction");

  // receive only inside a transaction
  a_rx_in_trans: assert property (@(posedge clk) disable iff (!rst_n)
    rx_en_r |-> trans_r) else $error("receive enabled outside transaction");

  // fill count never passes the buffer depth
  a_plen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    plen_r <= CNT_W'(PENDING_DEPTH)) else $error("pending length overflow");

  // receive and transmit are never both on
  a_rx_tx_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(rx_en_r && tx_en_r)) else $error("receive and transmit both enabled");
`endif

endmodule

// ===== rtl/core/i2c_register_pointer_target_unit.sv =====
`timescale 1ns / 1ps
// I2C register-pointer target, top level: input register, control stage,
// image and pending RAMs, result register. Uses i2crpt_pkg, i2crpt_ctrl, i2crpt_ram.
//
// One request (bus or local event) is accepted per clock while the result
// channel does not stall, and produces one result. An accepted request sits
// in the input register, then passes the control stage into the result
// register and the registered RAM read port. Back-to-back requests run at
// full rate; a stalled result stalls the input register and then the input
// channel. The register image (two banks) and pending buffer are RAMs with
// no reset; image entries must be written by the local side before the host
// reads them. The own-address register is written through the cfg port; the
// user must write it only while idle, as the block itself does not enforce it.
module i2c_register_pointer_target_unit import i2crpt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_own_address,
  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_operation,
  input  logic [6:0] in_matched_address,
  input  logic       in_direction_read,
  input  logic [7:0] in_bus_byte,
  input  logic       in_active_bank,
  input  logic       in_local_bank,
  input  logic [7:0] in_local_index,
  input  logic [7:0] in_local_value,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_tx_byte,
  output logic       out_tx_valid,
  output logic       out_pending_flag,
  output logic [7:0] out_pending_register,
  output logic [5:0] out_pending_count,
  output logic [7:0] out_pending_byte,
  output logic       out_transaction_active
);

  logic      in_v_r;
  item_t     item_r;
  logic      out_v_r;
  step_res_t res_r;
  step_res_t res;
  mem_req_t  mem_req;
  logic      adv;
  logic      in_acc;
  logic [7:0] img_q, pnd_q;

  assign cfg_ready = 1'b1;

  // pipeline flow control
  assign adv      = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_acc) begin
      in_v_r <= 1'b1;
    end else if (adv) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r <= '0;
    end else if (in_acc) begin
      item_r.op              <= op_e'(in_operation);
      item_r.matched_address <= in_matched_address;
      item_r.direction_read  <= in_direction_read;
      item_r.bus_byte        <= in_bus_byte;
      item_r.active_bank     <= in_active_bank;
      item_r.local_bank      <= in_local_bank;
      item_r.local_index     <= in_local_index;
      item_r.local_value     <= in_local_value;
    end
  end

  i2crpt_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_own_address (cfg_own_address),
    .step            (adv),
    .item            (item_r),
    .mem_req         (mem_req),
    .res             (res)
  );

  i2crpt_ram #(.AW(IMG_RAM_AW), .DW(8)) u_img_ram (
    .clk     (clk),
    .we      (mem_req.img_we),
    .waddr   (mem_req.img_waddr),
    .wdata   (mem_req.img_wdata),
    .re      (mem_req.img_re),
    .raddr   (mem_req.img_raddr),
    .rdata_r (img_q)
  );

  i2crpt_ram #(.AW(PEND_AW), .DW(8)) u_pnd_ram (
    .clk     (clk),
    .we      (mem_req.pnd_we),
    .waddr   (mem_req.pnd_waddr),
    .wdata   (mem_req.pnd_wdata),
    .re      (mem_req.pnd_re),
    .raddr   (mem_req.pnd_raddr),
    .rdata_r (pnd_q)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  // outputs; RAM data is gated by its hit flag
  assign out_valid              = out_v_r;
  assign out_tx_byte            = res_r.tx_hit ? img_q : 8'd0;
  assign out_tx_valid           = res_r.tx_valid;
  assign out_pending_flag       = res_r.pending_flag;
  assign out_pending_register   = res_r.pending_register;
  assign out_pending_count      = 6'(res_r.pending_count);
  assign out_pending_byte       = res_r.pnd_hit ? pnd_q : 8'd0;
  assign out_transaction_active = res_r.transaction_active;

`ifndef SYNTH
  // a result is either a transmit or a pending read, never both
  a_res_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(res_r.tx_valid && res_r.pnd_hit)) else $error("tx and pending read together");

  // an image hit only comes with a served transmit request
  a_tx_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_r.tx_hit |-> res_r.tx_valid) else $error("image hit without tx");

  // a served transmit request happens inside a transaction
  a_tx_trans: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_r.tx_valid |-> res_r.transaction_active)
    else $error("tx outside transaction");
`endif

endmodule
